@@ hdl/bpfa_pkg.sv @@
package bpfa_pkg;

  localparam int MAX_PAGES_DEF  = 131072;
  localparam int PAGE_SHIFT_DEF = 12;
  localparam int BASE_W         = 20;
  localparam int CNT_W          = 18;
  localparam int ADDR_W         = 32;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic REG_BASE_PAGE   = 1'b0;
  localparam logic REG_TOTAL_PAGES = 1'b1;

  localparam logic [1:0] OP_ALLOC_ONE = 2'd0;
  localparam logic [1:0] OP_FREE_ONE  = 2'd1;
  localparam logic [1:0] OP_ALLOC_RUN = 2'd2;
  localparam logic [1:0] OP_FREE_RUN  = 2'd3;

  typedef struct packed {
    logic              alloc;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  count;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_CLR,
    BK_SC_RD,
    BK_SC_BIT,
    BK_FL_RD,
    BK_FL_WR,
    BK_FR_CHK,
    BK_FR_RD,
    BK_FR_MOD,
    BK_DONE
  } back_state_t;

endpackage

@@ hdl/bpfa_front.sv @@
module bpfa_front import bpfa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [1:0]       op,
  input  logic [ADDR_W-1:0] addr,
  input  logic [CNT_W-1:0] count,
  input  logic             pop,
  output logic             full,
  output logic             cmd_valid,
  output cmd_t             cmd
);

  cmd_t       q [QUEUE_DEPTH];
  logic       wp;
  logic       rp;
  logic [1:0] fill;
  cmd_t       in_cmd;

  // single-page ops become runs of one
  always_comb begin
    in_cmd.addr = addr;
    case (op)
      OP_ALLOC_ONE: begin
        in_cmd.alloc = 1'b1;
        in_cmd.count = CNT_W'(1);
      end
      OP_ALLOC_RUN: begin
        in_cmd.alloc = 1'b1;
        in_cmd.count = count;
      end
      OP_FREE_ONE: begin
        in_cmd.alloc = 1'b0;
        in_cmd.count = CNT_W'(1);
      end
      default: begin
        in_cmd.alloc = 1'b0;
        in_cmd.count = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  assign full      = (fill == 2'(QUEUE_DEPTH));
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rp];

endmodule

@@ hdl/bpfa_back.sv @@
module bpfa_back import bpfa_pkg::*; #(
  parameter int MAX_PAGES  = MAX_PAGES_DEF,
  parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clr_req,
  input  logic [BASE_W-1:0] base_page,
  input  logic [CNT_W-1:0]  page_limit,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              pop,
  output back_stat_t        stat,
  output logic              done,
  output logic [ADDR_W-1:0] page_addr,
  output logic              ok,
  output logic [CNT_W-1:0]  free_count
);

  localparam int NW  = (MAX_PAGES + 31) / 32;
  localparam int AW  = (NW > 1) ? $clog2(NW) : 1;
  localparam int PIW = $clog2(MAX_PAGES) + 1;
  localparam logic [ADDR_W-1:0] PAGE_BYTES = ADDR_W'(1) << PAGE_SHIFT;

  back_state_t state, state_next;

  logic [31:0]   mem [NW];
  logic [31:0]   rdata;
  logic          re, we;
  logic [AW-1:0] rd_word, wr_word;
  logic [31:0]   wr_data;

  logic [PIW-1:0]    p, run_start, end_pg, fpg;
  logic [CNT_W-1:0]  len, cnt, i_cnt;
  logic [AW-1:0]     fw, clr_idx;
  logic [ADDR_W-1:0] cur, raddr;
  logic              rok;
  logic [CNT_W-1:0]  free;

  logic [31:0]       tot32, bb, p32, pg32;
  logic              p_out, cur_bit, hit, pg_out, last_i, fill_last, bad_count, fbit;
  logic [CNT_W-1:0]  len_inc, i_inc;
  logic [PIW-1:0]    p_inc, start_new;
  logic [31:0]       fmask;

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[rd_word];
    end
    if (we) begin
      mem[wr_word] <= wr_data;
    end
  end

  assign tot32     = {14'b0, page_limit};
  assign bb        = {12'b0, base_page} << PAGE_SHIFT;
  assign p32       = 32'(p);
  assign p_out     = p32 >= tot32;
  assign cur_bit   = rdata[p[4:0]];
  assign len_inc   = len + CNT_W'(1);
  assign hit       = len_inc == cnt;
  assign start_new = (len == '0) ? p : run_start;
  assign p_inc     = p + PIW'(1);
  assign pg32      = (cur - bb) >> PAGE_SHIFT;
  assign pg_out    = pg32 >= tot32;
  assign i_inc     = i_cnt + CNT_W'(1);
  assign last_i    = i_inc == cnt;
  assign fill_last = fw == AW'(end_pg >> 5);
  assign bad_count = (cmd.count == '0) || ({14'b0, cmd.count} > tot32);
  assign fbit      = rdata[fpg[4:0]];

  // bits of the fill word that lie inside the run
  always_comb begin
    logic [31:0] wpg;
    for (int b = 0; b < 32; b++) begin
      wpg      = (32'(fw) << 5) | 32'(b);
      fmask[b] = (wpg >= 32'(run_start)) && (wpg <= 32'(end_pg));
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          if (cmd.alloc) begin
            state_next = bad_count ? BK_DONE : BK_SC_RD;
          end else begin
            state_next = (cmd.count == '0) ? BK_DONE : BK_FR_CHK;
          end
        end
      end
      BK_CLR: begin
        if (clr_idx == AW'(NW - 1)) begin
          state_next = BK_IDLE;
        end
      end
      BK_SC_RD:  state_next = BK_SC_BIT;
      BK_SC_BIT: begin
        if (p_out) begin
          state_next = BK_DONE;
        end else if (!cur_bit && hit) begin
          state_next = BK_FL_RD;
        end else if (p_inc[4:0] == 5'd0) begin
          state_next = BK_SC_RD;
        end
      end
      BK_FL_RD: state_next = BK_FL_WR;
      BK_FL_WR: begin
        if (fill_last) begin
          state_next = BK_DONE;
        end else begin
          state_next = BK_FL_RD;
        end
      end
      BK_FR_CHK: begin
        if (!pg_out) begin
          state_next = BK_FR_RD;
        end else if (last_i) begin
          state_next = BK_DONE;
        end
      end
      BK_FR_RD:  state_next = BK_FR_MOD;
      BK_FR_MOD: state_next = last_i ? BK_DONE : BK_FR_CHK;
      BK_DONE:   state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
    if (clr_req) begin
      state_next = BK_CLR;
    end
  end

  always_comb begin
    re      = 1'b0;
    we      = 1'b0;
    rd_word = '0;
    wr_word = '0;
    wr_data = '0;
    pop     = 1'b0;
    case (state)
      BK_IDLE: pop = cmd_valid && !clr_req;
      BK_CLR: begin
        we      = 1'b1;
        wr_word = clr_idx;
      end
      BK_SC_RD: begin
        re      = 1'b1;
        rd_word = AW'(p >> 5);
      end
      BK_FL_RD: begin
        re      = 1'b1;
        rd_word = fw;
      end
      BK_FL_WR: begin
        we      = 1'b1;
        wr_word = fw;
        wr_data = rdata | fmask;
      end
      BK_FR_RD: begin
        re      = 1'b1;
        rd_word = AW'(fpg >> 5);
      end
      BK_FR_MOD: begin
        we      = fbit;
        wr_word = AW'(fpg >> 5);
        wr_data = rdata & ~(32'(1) << fpg[4:0]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_CLR;
      clr_idx <= '0;
      free    <= '0;
      rok     <= 1'b0;
      raddr   <= '0;
    end else begin
      state <= state_next;
      if (clr_req) begin
        clr_idx <= '0;
      end else if (state == BK_CLR) begin
        clr_idx <= clr_idx + AW'(1);
        free    <= page_limit;
      end
      case (state)
        BK_IDLE: begin
          if (pop) begin
            p         <= '0;
            len       <= '0;
            run_start <= '0;
            cnt       <= cmd.count;
            cur       <= cmd.addr;
            i_cnt     <= '0;
            rok       <= 1'b0;
            raddr     <= '0;
          end
        end
        BK_SC_BIT: begin
          if (!p_out) begin
            if (cur_bit) begin
              len <= '0;
              p   <= p_inc;
            end else if (hit) begin
              run_start <= start_new;
              end_pg    <= p;
              fw        <= AW'(start_new >> 5);
              free      <= free - cnt;
              rok       <= 1'b1;
              raddr     <= bb + (32'(start_new) << PAGE_SHIFT);
            end else begin
              run_start <= start_new;
              len       <= len_inc;
              p         <= p_inc;
            end
          end
        end
        BK_FL_WR: fw <= fw + AW'(1);
        BK_FR_CHK: begin
          if (pg_out) begin
            i_cnt <= i_inc;
            cur   <= cur + PAGE_BYTES;
          end else begin
            fpg <= PIW'(pg32);
          end
        end
        BK_FR_MOD: begin
          if (fbit) begin
            free <= free + CNT_W'(1);
            rok  <= 1'b1;
          end
          i_cnt <= i_inc;
          cur   <= cur + PAGE_BYTES;
        end
        default: begin
        end
      endcase
    end
  end

  assign stat.clearing = (state == BK_CLR);
  assign done          = (state == BK_DONE);
  assign page_addr     = raddr;
  assign ok            = rok;
  assign free_count    = free;

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == BK_IDLE))
    else $error("command taken outside idle");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DONE) |-> ({14'b0, free} <= tot32))
    else $error("free count above total");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !rok) |-> (raddr == '0))
    else $error("failed request with nonzero address");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == BK_IDLE || state == BK_DONE) |-> !we)
    else $error("bitmap write while not working");

endmodule

@@ hdl/bitmap_page_frame_allocator.sv @@
// channel | signals                       | handshake
// config  | wr_en wr_index wr_data        | write at edge with wr_en high
// request | op addr count                 | beat taken when start && !busy
// result  | page_addr ok free_count       | one-cycle done strobe, no stall
//
// allocations scan one page per cycle plus a word read every 32 pages,
// then write the run back one word at a time, each word read then written
// frees range-check each page, then read and clear its bit only for an in-range page
// after reset and after a page count write a clearing pass over all
// (MAX_PAGES+31)/32 bitmap words (4096 by default) holds busy high
// a two-entry command queue sits between request and bitmap engine
module bitmap_page_frame_allocator import bpfa_pkg::*; #(
  parameter int MAX_PAGES  = MAX_PAGES_DEF,
  parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic              wr_index,
  input  logic [BASE_W-1:0] wr_data,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        op,
  input  logic [ADDR_W-1:0] addr,
  input  logic [CNT_W-1:0]  count,
  output logic              done,
  output logic [ADDR_W-1:0] page_addr,
  output logic              ok,
  output logic [CNT_W-1:0]  free_count
);

  logic [BASE_W-1:0] base_page;
  logic [CNT_W-1:0]  page_limit;
  logic              clr_req;
  logic              full, cmd_valid, pop, push;
  logic [CNT_W-1:0]  wr_total;
  cmd_t              cmd;
  back_stat_t        stat;

  assign clr_req  = wr_en && (wr_index == REG_TOTAL_PAGES);
  assign wr_total = ({14'b0, wr_data[CNT_W-1:0]} > 32'(MAX_PAGES)) ?
                    CNT_W'(MAX_PAGES) : wr_data[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      base_page  <= '0;
      page_limit <= '0;
    end else if (wr_en) begin
      if (wr_index == REG_BASE_PAGE) begin
        base_page <= wr_data;
      end else begin
        page_limit <= wr_total;
      end
    end
  end

  assign busy = full || stat.clearing || clr_req;
  assign push = start && !busy;

  bpfa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .op        (op),
    .addr      (addr),
    .count     (count),
    .pop       (pop),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  bpfa_back #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .clr_req     (clr_req),
    .base_page   (base_page),
    .page_limit  (page_limit),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .pop         (pop),
    .stat        (stat),
    .done        (done),
    .page_addr   (page_addr),
    .ok          (ok),
    .free_count  (free_count)
  );

endmodule
